@@ src/eepa_pkg.sv @@
// Package for the encoder edge period accumulator.
// Holds the request opcodes, the pending flag positions and the result layout.
// No dependencies; used by the top level and by its checker.
package eepa_pkg;

	// Request opcodes, carried on the slave-side tuser
	typedef enum logic [1:0] {
		OP_EDGE     = 2'd0,
		OP_SNAPSHOT = 2'd1,
		OP_DROP     = 2'd2,
		OP_UNUSED   = 2'd3
	} eepa_op_t;

	// Pending flag bit positions
	localparam int unsigned FLAG_EDGE_BIT     = 0;
	localparam int unsigned FLAG_PERIOD_BIT   = 1;
	localparam int unsigned FLAG_DIRRESET_BIT = 2;
	localparam int unsigned FLAG_ZERO_BIT     = 3;
	localparam int unsigned FLAG_DROP_BIT     = 4;

	// Window count at which a further period drops the aggregate
	localparam logic [15:0] COUNT_LIMIT = 16'd65535;

	// Valid direction codes on the 8-bit input and their stored 2-bit forms
	localparam logic [7:0] DIR8_POS = 8'h01;
	localparam logic [7:0] DIR8_NEG = 8'hFF;
	localparam logic [1:0] DIR2_POS = 2'b01;
	localparam logic [1:0] DIR2_NEG = 2'b11;

	// Input payload: stamp in the low 32 bits, direction above it
	typedef struct packed {
		logic signed [7:0] edge_direction;
		logic [31:0]       stamp_cycles;
	} eepa_req_t;

	// Result payload, last field in the lowest bits (248 bits, 31 bytes)
	typedef struct packed {
		logic [31:0]       drop_total;
		logic [31:0]       zero_period_total;
		logic [31:0]       direction_reset_total;
		logic [31:0]       invalid_direction_total;
		logic [4:0]        flag_bits;
		logic signed [1:0] held_direction;
		logic [15:0]       periods_in_window;
		logic [31:0]       event_number;
		logic [31:0]       edge_age;
		logic [31:0]       period_sum;
		logic              accepted;
	} eepa_result_t;

endpackage

@@ src/encoder_edge_period_accumulator_unit.sv @@
// Encoder edge period accumulator: top level.
// Depends on eepa_pkg for opcodes, flag positions and the result layout.
// Usage:
//   Requests arrive on the s_axis channel. tuser carries the opcode (edge,
//   snapshot, drop); tdata carries the 32-bit cycle stamp and the signed
//   8-bit edge direction. Every request gives exactly one result on the
//   m_axis channel, in order: an accepted flag, the snapshot fields (sum,
//   age of the last edge, event number, window count, direction, pending
//   flags; zero except for a snapshot) and four saturating statistics.
//   A request waits in the input register, then the state update and result
//   are formed in one pass into the result register. Throughput is one
//   request per cycle while the receiver does not stall; the state update
//   of one request is visible to the very next one.
//   When the receiver stalls, the result is held in the result register and
//   one further request may wait in the input register; s_axis_tready drops
//   only once both are full.
//   Reset clears the window, the held edge, the flags, the event number and
//   all statistics, and empties both registers.
module encoder_edge_period_accumulator_unit
	import eepa_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [31:0] stamp_cycles, [39:32] edge_direction
	input  logic [39:0]  s_axis_tdata,
	// [1:0] opcode
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [0] accepted, [32:1] period_sum, [64:33] edge_age, [96:65] event_number,
	// [112:97] periods_in_window, [114:113] held_direction, [119:115] flag_bits,
	// [151:120] invalid_direction_total, [183:152] direction_reset_total,
	// [215:184] zero_period_total, [247:216] drop_total
	output logic [247:0] m_axis_tdata
);

	// Saturating increment for the statistics counters
	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// Input register stage
	logic      valid_s1;
	eepa_op_t  opcode_s1;
	eepa_req_t req_s1;

	// Result register stage
	logic         valid_s2;
	eepa_result_t res_s2;

	// Accumulator state
	logic        edge_seen_q;
	logic [1:0]  direction_q;
	logic [31:0] last_stamp_q;
	logic [31:0] sum_q;
	logic [15:0] count_q;
	logic [4:0]  pending_q;
	logic [31:0] event_q;
	logic [31:0] invalid_q;
	logic [31:0] dirreset_q;
	logic [31:0] zero_q;
	logic [31:0] drop_q;

	// Next-state values and the result formed in this pass
	logic         edge_seen_d;
	logic [1:0]   direction_d;
	logic [31:0]  last_stamp_d;
	logic [31:0]  sum_d;
	logic [15:0]  count_d;
	logic [4:0]   pending_d;
	logic [31:0]  event_d;
	logic [31:0]  invalid_d;
	logic [31:0]  dirreset_d;
	logic [31:0]  zero_d;
	logic [31:0]  drop_d;
	eepa_result_t res_d;

	logic        advance;
	logic        dir_ok;
	logic [1:0]  dir2;
	logic [31:0] period;

	// Handshake: the input stage moves on when the result register is free or being read
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = res_s2;

	// Direction decode and period between edges
	assign dir_ok = (req_s1.edge_direction == DIR8_POS) || (req_s1.edge_direction == DIR8_NEG);
	assign dir2   = (req_s1.edge_direction == DIR8_POS) ? DIR2_POS : DIR2_NEG;
	assign period = req_s1.stamp_cycles - last_stamp_q;

	// Single pass over the request in the input register
	always_comb begin
		edge_seen_d  = edge_seen_q;
		direction_d  = direction_q;
		last_stamp_d = last_stamp_q;
		sum_d        = sum_q;
		count_d      = count_q;
		pending_d    = pending_q;
		event_d      = event_q;
		invalid_d    = invalid_q;
		dirreset_d   = dirreset_q;
		zero_d       = zero_q;
		drop_d       = drop_q;
		res_d        = '0;

		case (opcode_s1)
			OP_EDGE: begin
				if (!dir_ok) begin
					invalid_d = sat_inc(invalid_q);
				end else begin
					event_d = event_q + 32'd1;
					if (!edge_seen_q) begin
						// First edge after reset or a drop
						last_stamp_d             = req_s1.stamp_cycles;
						direction_d              = dir2;
						edge_seen_d              = 1'b1;
						pending_d[FLAG_EDGE_BIT] = 1'b1;
						res_d.accepted           = 1'b1;
					end else if (dir2 != direction_q) begin
						// Direction change restarts the window
						sum_d                        = '0;
						count_d                      = '0;
						last_stamp_d                 = req_s1.stamp_cycles;
						direction_d                  = dir2;
						pending_d[FLAG_EDGE_BIT]     = 1'b1;
						pending_d[FLAG_DIRRESET_BIT] = 1'b1;
						dirreset_d                   = sat_inc(dirreset_q);
						res_d.accepted               = 1'b1;
					end else begin
						last_stamp_d             = req_s1.stamp_cycles;
						pending_d[FLAG_EDGE_BIT] = 1'b1;
						if (period == 32'd0) begin
							pending_d[FLAG_ZERO_BIT] = 1'b1;
							zero_d                   = sat_inc(zero_q);
						end else if (count_q >= COUNT_LIMIT || period > ~sum_q) begin
							// Window full or sum would overflow: drop the aggregate
							sum_d                      = '0;
							count_d                    = '0;
							edge_seen_d                = 1'b0;
							direction_d                = '0;
							pending_d[FLAG_EDGE_BIT]   = 1'b0;
							pending_d[FLAG_PERIOD_BIT] = 1'b0;
							pending_d[FLAG_DROP_BIT]   = 1'b1;
							drop_d                     = sat_inc(drop_q);
						end else begin
							sum_d                      = sum_q + period;
							count_d                    = count_q + 16'd1;
							pending_d[FLAG_PERIOD_BIT] = 1'b1;
							res_d.accepted             = 1'b1;
						end
					end
				end
			end
			OP_SNAPSHOT: begin
				res_d.accepted          = 1'b1;
				res_d.period_sum        = sum_q;
				res_d.edge_age          = edge_seen_q ? period : 32'd0;
				res_d.event_number      = event_q;
				res_d.periods_in_window = count_q;
				res_d.held_direction    = direction_q;
				res_d.flag_bits         = pending_q;
				sum_d                   = '0;
				count_d                 = '0;
				pending_d               = '0;
				pending_d[FLAG_EDGE_BIT] = edge_seen_q;
			end
			OP_DROP: begin
				sum_d                      = '0;
				count_d                    = '0;
				edge_seen_d                = 1'b0;
				direction_d                = '0;
				pending_d[FLAG_EDGE_BIT]   = 1'b0;
				pending_d[FLAG_PERIOD_BIT] = 1'b0;
				pending_d[FLAG_DROP_BIT]   = 1'b1;
				drop_d                     = sat_inc(drop_q);
				res_d.accepted             = 1'b1;
			end
			default: begin
			end
		endcase

		// Statistics as they stand after the request
		res_d.invalid_direction_total = invalid_d;
		res_d.direction_reset_total   = dirreset_d;
		res_d.zero_period_total       = zero_d;
		res_d.drop_total              = drop_d;
	end

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			opcode_s1 <= eepa_op_t'(s_axis_tuser);
			req_s1    <= s_axis_tdata;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	// Accumulator state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_seen_q  <= 1'b0;
			direction_q  <= '0;
			last_stamp_q <= '0;
			sum_q        <= '0;
			count_q      <= '0;
			pending_q    <= '0;
			event_q      <= '0;
			invalid_q    <= '0;
			dirreset_q   <= '0;
			zero_q       <= '0;
			drop_q       <= '0;
		end else if (advance) begin
			edge_seen_q  <= edge_seen_d;
			direction_q  <= direction_d;
			last_stamp_q <= last_stamp_d;
			sum_q        <= sum_d;
			count_q      <= count_d;
			pending_q    <= pending_d;
			event_q      <= event_d;
			invalid_q    <= invalid_d;
			dirreset_q   <= dirreset_d;
			zero_q       <= zero_d;
			drop_q       <= drop_d;
		end
	end

endmodule

@@ src/eepa_checker.sv @@
// Port-level checker for the encoder edge period accumulator.
// Depends on eepa_pkg for the flag positions; bound to the top level below.
module eepa_port_assertions
	import eepa_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [247:0] m_axis_tdata
);

	eepa_result_t res;

	assign res = m_axis_tdata;

	// A stalled result stays up and unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Every accepted request is followed by a result on offer, its own or an earlier stalled one
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
		else $error("no result offered after an accepted request");

	// A held direction is shown exactly when the edge flag is set
	a_dir_edge: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((res.held_direction != 2'sd0) == res.flag_bits[FLAG_EDGE_BIT]))
		else $error("held direction disagrees with edge flag");

	// A summed period implies a held edge
	a_period_edge: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.flag_bits[FLAG_PERIOD_BIT] |-> res.flag_bits[FLAG_EDGE_BIT])
		else $error("period flag without edge flag");

	// Only non-zero periods are summed, so the sum is zero exactly when the count is
	a_sum_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((res.period_sum == 32'd0) == (res.periods_in_window == 16'd0)))
		else $error("window sum and count disagree");

endmodule

bind encoder_edge_period_accumulator_unit eepa_port_assertions u_port_assertions (.*);

@@ tb/eepa_checker.sv @@
`timescale 1ns / 100ps
// Checker for the encoder edge period accumulator: watches both stream channels,
// predicts every result from the accepted requests and compares it field by field.
// Depends on eepa_pkg for the opcodes, flag positions, direction codes and layouts.
module eepa_checker
	import eepa_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	// [31:0] stamp_cycles, [39:32] edge_direction
	input  logic [39:0]  s_axis_tdata,
	// [1:0] opcode
	input  logic [1:0]   s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [0] accepted, [32:1] period_sum, [64:33] edge_age, [96:65] event_number,
	// [112:97] periods_in_window, [114:113] held_direction, [119:115] flag_bits,
	// [151:120] invalid_direction_total, [183:152] direction_reset_total,
	// [215:184] zero_period_total, [247:216] drop_total
	input  logic [247:0] m_axis_tdata,
	output int           mismatch_count,
	output int           results_owed,
	output int           results_checked
);

	localparam int PRINT_CAP = 40;

	// Shadow copy of the accumulator state, all starting at zero.
	logic        edge_held        = 1'b0;
	logic [1:0]  held_dir         = '0;
	logic [31:0] last_edge_stamp  = '0;
	logic [31:0] window_sum       = '0;
	logic [15:0] window_periods   = '0;
	logic [4:0]  shadow_flags     = '0;
	logic [31:0] valid_edges      = '0;
	logic [31:0] invalid_dir_hits = '0;
	logic [31:0] dir_reset_hits   = '0;
	logic [31:0] zero_period_hits = '0;
	logic [31:0] drop_hits        = '0;

	eepa_result_t expected_results[$];
	int           mismatches  = 0;
	int           owed        = 0;
	int           result_tally = 0;

	assign mismatch_count  = mismatches;
	assign results_owed    = owed;
	assign results_checked = result_tally;

	function automatic logic [31:0] bump_saturating(logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	// Throws away the window and the held edge and records the drop.
	function automatic void drop_window();
		window_sum = '0;
		window_periods = '0;
		edge_held = 1'b0;
		held_dir = '0;
		shadow_flags[FLAG_EDGE_BIT] = 1'b0;
		shadow_flags[FLAG_PERIOD_BIT] = 1'b0;
		shadow_flags[FLAG_DROP_BIT] = 1'b1;
		drop_hits = bump_saturating(drop_hits);
	endfunction

	// Applies one request to the shadow state and returns the result it gives.
	function automatic eepa_result_t accumulate_request(eepa_op_t op, logic [31:0] stamp,
			logic [7:0] dir8);
		eepa_result_t res;
		logic [1:0]   dir2;
		logic [31:0]  period;
		res = '0;
		case (op)
			OP_EDGE: begin
				if (dir8 != DIR8_POS && dir8 != DIR8_NEG) begin
					invalid_dir_hits = bump_saturating(invalid_dir_hits);
				end else begin
					dir2 = (dir8 == DIR8_POS) ? DIR2_POS : DIR2_NEG;
					valid_edges = valid_edges + 32'd1;
					if (!edge_held) begin
						// First edge only arms the window.
						last_edge_stamp = stamp;
						held_dir = dir2;
						edge_held = 1'b1;
						shadow_flags[FLAG_EDGE_BIT] = 1'b1;
						res.accepted = 1'b1;
					end else if (dir2 != held_dir) begin
						// A reversal starts the window again from this edge.
						window_sum = '0;
						window_periods = '0;
						last_edge_stamp = stamp;
						held_dir = dir2;
						shadow_flags[FLAG_EDGE_BIT] = 1'b1;
						shadow_flags[FLAG_DIRRESET_BIT] = 1'b1;
						dir_reset_hits = bump_saturating(dir_reset_hits);
						res.accepted = 1'b1;
					end else begin
						period = stamp - last_edge_stamp;
						last_edge_stamp = stamp;
						shadow_flags[FLAG_EDGE_BIT] = 1'b1;
						if (period == '0) begin
							shadow_flags[FLAG_ZERO_BIT] = 1'b1;
							zero_period_hits = bump_saturating(zero_period_hits);
						end else if (window_periods >= COUNT_LIMIT || period > ~window_sum) begin
							drop_window();
						end else begin
							window_sum = window_sum + period;
							window_periods = window_periods + 16'd1;
							shadow_flags[FLAG_PERIOD_BIT] = 1'b1;
							res.accepted = 1'b1;
						end
					end
				end
			end
			OP_SNAPSHOT: begin
				res.accepted = 1'b1;
				res.period_sum = window_sum;
				res.edge_age = edge_held ? stamp - last_edge_stamp : '0;
				res.event_number = valid_edges;
				res.periods_in_window = window_periods;
				res.held_direction = held_dir;
				res.flag_bits = shadow_flags;
				window_sum = '0;
				window_periods = '0;
				shadow_flags = '0;
				shadow_flags[FLAG_EDGE_BIT] = edge_held;
			end
			OP_DROP: begin
				drop_window();
				res.accepted = 1'b1;
			end
			OP_UNUSED: begin
			end
		endcase
		res.invalid_direction_total = invalid_dir_hits;
		res.direction_reset_total = dir_reset_hits;
		res.zero_period_total = zero_period_hits;
		res.drop_total = drop_hits;
		return res;
	endfunction

	// Prints one line per mismatch, up to a cap, and counts every one.
	task automatic report_mismatch(string what);
		if (mismatches < PRINT_CAP)
			$display("MISMATCH at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(string field, logic [31:0] got_v, logic [31:0] want_v);
		if (got_v !== want_v)
			report_mismatch($sformatf("result %0d %s got 0x%08h expected 0x%08h",
				result_tally, field, got_v, want_v));
	endtask

	task automatic compare_result(eepa_result_t got, eepa_result_t want);
		check_field("accepted", 32'(got.accepted), 32'(want.accepted));
		check_field("period_sum", got.period_sum, want.period_sum);
		check_field("edge_age", got.edge_age, want.edge_age);
		check_field("event_number", got.event_number, want.event_number);
		check_field("periods_in_window", 32'(got.periods_in_window),
			32'(want.periods_in_window));
		check_field("held_direction", 32'(got.held_direction), 32'(want.held_direction));
		check_field("flag_bits", 32'(got.flag_bits), 32'(want.flag_bits));
		check_field("invalid_direction_total", got.invalid_direction_total,
			want.invalid_direction_total);
		check_field("direction_reset_total", got.direction_reset_total,
			want.direction_reset_total);
		check_field("zero_period_total", got.zero_period_total, want.zero_period_total);
		check_field("drop_total", got.drop_total, want.drop_total);
	endtask

	// Both channels are sampled at the rising edge, before the block updates them.
	always @(posedge clk) begin
		eepa_req_t    req;
		eepa_result_t got;
		eepa_result_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				req = s_axis_tdata;
				expected_results.push_back(accumulate_request(eepa_op_t'(s_axis_tuser),
					req.stamp_cycles, req.edge_direction));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with no request waiting",
						result_tally));
				end else begin
					want = expected_results.pop_front();
					compare_result(got, want);
				end
				result_tally++;
			end
			owed = expected_results.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Top of the encoder edge period accumulator testbench: clock, reset, request
// stimulus, result back-pressure, watchdog and verdict. Depends on eepa_pkg,
// the block encoder_edge_period_accumulator_unit and the eepa_checker module.
module testbench
	import eepa_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int HOLD_OFF_CYCLES = 48;
	localparam int DRAIN_CYCLES = 8;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [39:0]  s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [247:0] m_axis_tdata;

	int mismatch_count;
	int results_owed;
	int results_checked;

	// Stimulus controls: idling on either side and the receiver hold-off.
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;
	int          hold_off_asked = 0;
	int          hold_off_done = 0;
	int          quiet_cycles = 0;
	int          op_tally[4] = '{default: 0};
	logic [31:0] stamp_now = '0;
	logic [7:0]  run_dir = DIR8_POS;

	encoder_edge_period_accumulator_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	eepa_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.mismatch_count  (mismatch_count),
		.results_owed    (results_owed),
		.results_checked (results_checked)
	);

	// 2 ns clock.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Ends the run if neither channel moves a request or a result for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("encoder_edge_period_accumulator_unit verification failed");
				$finish;
			end
		end
	end

	// Result side: random stalls, and a long hold-off whenever the stimulus asks.
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_asked != hold_off_done) begin
				hold_off_done = hold_off_asked;
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			if (rx_idle_on && $urandom_range(99) < 15)
				m_axis_tready <= 1'b0;
			else
				m_axis_tready <= 1'b1;
		end
	end

	// Offers one request, with random idle cycles first, and returns once it is taken.
	task automatic send_request(eepa_op_t op, logic [31:0] stamp, logic [7:0] dir8);
		eepa_req_t req;
		req.stamp_cycles = stamp;
		req.edge_direction = dir8;
		while (tx_idle_on && $urandom_range(99) < 15) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= {8'($urandom), $urandom};
			s_axis_tuser <= 2'($urandom);
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= req;
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		op_tally[int'(op)]++;
	endtask

	// Stops offering and waits until every request has produced its result.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (results_owed == 0);
		@(posedge clk);
	endtask

	// Mostly well-formed runs of same-direction edges, with reversals, zero and huge
	// periods, bad direction codes, snapshots, drops and the unused opcode mixed in.
	task automatic send_random_request();
		int          pick;
		int          roll;
		logic [31:0] step;
		logic [7:0]  dir8;
		pick = $urandom_range(99);
		if (pick < 72) begin
			case ($urandom_range(19))
				0:       step = '0;
				1:       step = $urandom;
				2:       step = $urandom_range(32'hFFFF_FFFF, 32'hC000_0000);
				default: step = $urandom_range(2000, 1);
			endcase
			stamp_now += step;
			roll = $urandom_range(99);
			if (roll < 8)
				run_dir = (run_dir == DIR8_POS) ? DIR8_NEG : DIR8_POS;
			if (roll >= 8 && roll < 14)
				dir8 = 8'($urandom);
			else
				dir8 = run_dir;
			send_request(OP_EDGE, stamp_now, dir8);
		end else if (pick < 88) begin
			if ($urandom_range(9) == 0)
				send_request(OP_SNAPSHOT, $urandom, 8'($urandom));
			else
				send_request(OP_SNAPSHOT, stamp_now + $urandom_range(500), 8'($urandom));
		end else if (pick < 95) begin
			send_request(OP_DROP, $urandom, 8'($urandom));
		end else begin
			send_request(OP_UNUSED, $urandom, 8'($urandom));
		end
	endtask

	task automatic run_random(int count, int hold_at);
		int n;
		for (n = 0; n < count; n++) begin
			if (n == hold_at)
				hold_off_asked++;
			send_random_request();
		end
	endtask

	// Short directed list: reset snapshot, bad directions, first edge, zero period,
	// reversal, stamp wrap, sum overflow, an exact full sum, drop and unused opcode.
	task automatic run_directed();
		send_request(OP_SNAPSHOT, 32'h0000_0010, 8'h00);
		send_request(OP_EDGE, 32'h0000_0005, 8'h00);
		send_request(OP_EDGE, 32'h0000_0006, 8'h80);
		send_request(OP_EDGE, 32'h0000_0007, 8'h7F);
		send_request(OP_EDGE, 32'h0000_0000, DIR8_POS);
		send_request(OP_EDGE, 32'h0000_0064, DIR8_POS);
		send_request(OP_EDGE, 32'h0000_0064, DIR8_POS);
		send_request(OP_EDGE, 32'h0000_0096, DIR8_NEG);
		send_request(OP_EDGE, 32'hFFFF_FFF0, DIR8_NEG);
		send_request(OP_EDGE, 32'h0000_0010, DIR8_NEG);
		send_request(OP_SNAPSHOT, 32'h0000_0020, 8'h00);
		send_request(OP_EDGE, 32'hFFFF_FFFF, DIR8_POS);
		send_request(OP_EDGE, 32'h0000_0005, DIR8_POS);
		send_request(OP_SNAPSHOT, 32'hFFFF_FFFF, 8'hFF);
		send_request(OP_DROP, 32'h1234_5678, DIR8_POS);
		send_request(OP_UNUSED, 32'h8765_4321, DIR8_NEG);
		send_request(OP_SNAPSHOT, 32'h0000_0000, 8'h00);
		send_request(OP_EDGE, 32'h8000_0000, DIR8_NEG);
		send_request(OP_EDGE, 32'h0000_0000, DIR8_NEG);
		send_request(OP_EDGE, 32'h7FFF_FFFF, DIR8_NEG);
		send_request(OP_EDGE, 32'h8000_0000, DIR8_NEG);
		send_request(OP_SNAPSHOT, 32'h8000_0001, 8'h01);
		send_request(OP_DROP, 32'h0000_0000, 8'h00);
		send_request(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF);
	endtask

	// Request side: reset, then the stimulus phases, then the verdict.
	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= OP_EDGE;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		run_directed();
		drain_results();

		stamp_now = $urandom;
		run_random(300, 120);

		// Long stretch with neither side idling.
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		run_random(120, -1);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;

		run_random(280, -1);
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d edge, %0d snapshot, %0d drop and %0d unused requests.",
			op_tally[int'(OP_EDGE)], op_tally[int'(OP_SNAPSHOT)], op_tally[int'(OP_DROP)],
			op_tally[int'(OP_UNUSED)]);
		$display("Checked %0d results across a long result hold-off and a full drain pause.",
			results_checked);
		if (mismatch_count == 0)
			$display("encoder_edge_period_accumulator_unit verification clean");
		else
			$display("encoder_edge_period_accumulator_unit verification failed");
		$finish;
	end

endmodule
